// ----- hw/rtl/jpmd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpmd_pkg
// shared types, register codes and fixed-point constants of the joint drive
// ----------------------------------------------------------------------------
package jpmd_pkg;

  // joints and encoder preset (defaults of top-level parameters)
  localparam int          JOINTS_DEF       = 5;
  localparam logic [31:0] COUNT_PRESET_DEF = 32'h1000_0000;

  // configuration registers
  localparam int SCALE_REGS = 5;
  localparam int SIDX_W     = $clog2(SCALE_REGS);
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_ONE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_TWO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_THREE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FOUR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FIVE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KP          = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KI          = 3'd6;

  localparam logic [31:0] KP_RESET = 32'd33554432;
  localparam logic [31:0] KI_RESET = 32'd50332;

  // joint whose direction pair is wired the other way round
  localparam logic [2:0] INVERTED_JOINT = 3'd4;

  localparam logic [15:0] DIR_RESET = 16'hFFFF;

  // dac mapping: offset = |v| / 24576 = (|v| >> 13) / 3, clamped to span
  localparam int          DAC_SHIFT    = 13;
  localparam logic [15:0] DAC_ZERO     = 16'd32768;
  localparam logic [14:0] DAC_SPAN     = 15'd16384;
  localparam logic [15:0] DAC_CLAMP_X  = 16'd49152;
  localparam logic [31:0] RECIP3       = 32'd43691;
  localparam int          RECIP3_SHIFT = 17;

  // integral scaling: sample period of 0.01 s is a divide by 100
  localparam int DIV_BY    = 100;
  localparam int DIV_W     = 64;
  localparam int DIV_DIGIT = 4;
  localparam int DIV_REM_W = $clog2(DIV_BY);

  typedef struct packed {
    logic [2:0]         joint;
    logic [31:0]        encoder_count;
    logic signed [31:0] target_angle;
  } in_word_t;

  typedef struct packed {
    logic [15:0]        dac_code;
    logic [15:0]        direction_word;
    logic signed [31:0] measured_angle;
  } out_word_t;

  function automatic logic [31:0] scale_reset(input logic [SIDX_W-1:0] idx);
    logic [31:0] r;
    case (idx)
      REG_SCALE_ONE[SIDX_W-1:0]:   r = 32'd98956047;
      REG_SCALE_TWO[SIDX_W-1:0]:   r = 32'd59357268;
      REG_SCALE_THREE[SIDX_W-1:0]: r = 32'd89960042;
      REG_SCALE_FOUR[SIDX_W-1:0]:  r = 32'd109951163;
      REG_SCALE_FIVE[SIDX_W-1:0]:  r = 32'd229873744;
      default:                     r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/joint_pi_motor_drive.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_pi_motor_drive
// per-joint pi position drive: encoder count in, dac code and direction out
// ----------------------------------------------------------------------------
// each input word names a joint, its raw encoder count and a q16.16 target
// angle; one output word comes back with the dac code, the whole 16-bit
// direction word and the measured angle. words for a joint index at or above
// the joint count are taken and dropped with no result and no state change.
// a word passes from acceptance to result through five uses of one shared
// 32x32 multiplier (angle scale, kp term, two halves of the ki term, dac
// reciprocal) and a digit-serial divide by 100 for the 0.01 s sample period.
// the next word is taken once the previous result has been loaded into the
// output register, which may still be waiting on stall.
// ----------------------------------------------------------------------------
module joint_pi_motor_drive #(
  parameter int          JOINTS       = jpmd_pkg::JOINTS_DEF,
  parameter logic [31:0] COUNT_PRESET = jpmd_pkg::COUNT_PRESET_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input words
  input  logic                                in_valid,
  output logic                                in_stall,
  input  jpmd_pkg::in_word_t                  in_data,
  // result words
  output logic                                out_valid,
  input  logic                                out_stall,
  output jpmd_pkg::out_word_t                 out_data,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [jpmd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_data
);

  localparam int NJ = (JOINTS < jpmd_pkg::SCALE_REGS) ? JOINTS : jpmd_pkg::SCALE_REGS;
  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int SW = jpmd_pkg::SIDX_W;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_ANG, S_ANGLE, S_ERR, S_SUM, S_MUL_ILO, S_MUL_IHI, S_IACC,
    S_DIV_GO, S_DIV, S_VOLT, S_MAG, S_MUL_DAC, S_DAC, S_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [31:0] scale [jpmd_pkg::SCALE_REGS];
  logic [31:0] kp;
  logic [31:0] ki;

  // kept state
  logic signed [47:0] integral [JOINTS];
  logic [15:0]        direction_bits;

  // working registers of one word
  logic [2:0]         jr;
  logic [31:0]        diff_mag;
  logic               diff_neg;
  logic signed [31:0] target;
  logic [31:0]        scale_sel;
  logic signed [47:0] int_old;
  logic signed [31:0] angle;
  logic signed [32:0] err;
  logic [31:0]        err_mag;
  logic               err_neg;
  logic [47:0]        sum_mag;
  logic               sum_neg;
  logic [47:0]        pm;
  logic [79:0]        acc;
  logic signed [59:0] vreg;
  logic [15:0]        x16;
  logic               big;
  logic               vpos;
  logic [15:0]        dac;

  // shared multiplier and divider
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic        div_start;
  logic [63:0] div_q;
  logic        div_done;

  // combinational next values
  logic               in_take;
  logic               joint_ok;
  logic [32:0]        diff_up;
  logic [32:0]        diff_dn;
  logic [64:0]        rnd;
  logic [40:0]        q;
  logic signed [31:0] angle_next;
  logic [32:0]        e_fwd;
  logic [32:0]        e_rev;
  logic [48:0]        s49;
  logic signed [47:0] sum_next;
  logic [47:0]        sum_mag_next;
  logic [59:0]        pterm;
  logic [59:0]        iterm;
  logic [59:0]        vmag;
  logic [46:0]        vx;
  logic [14:0]        off;
  logic [3:0]         sh;
  logic [1:0]         pair;
  logic [15:0]        dir_next;
  logic               slot_free;

  jpmd_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  jpmd_div100 u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc[79:16]),
    .quotient (div_q),
    .done     (div_done)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign joint_ok  = ({1'b0, in_data.joint} < 4'(NJ));
  assign slot_free = !out_valid || !out_stall;
  assign div_start = (state == S_DIV_GO);

  // count offset from the preset, as sign and magnitude
  assign diff_up = {1'b0, in_data.encoder_count} - {1'b0, COUNT_PRESET};
  assign diff_dn = {1'b0, COUNT_PRESET} - {1'b0, in_data.encoder_count};

  // angle: product in 2^-40 deg, round half away from zero to q16.16, saturate
  always_comb begin
    rnd = {1'b0, prod} + 65'h80_0000;
    q   = rnd[64:24];
    if (diff_neg) begin
      angle_next = (q > 41'h0_8000_0000) ? 32'sh8000_0000 : $signed(32'd0 - q[31:0]);
    end else begin
      angle_next = (q > 41'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
    end
  end

  // error both ways round so the magnitude needs no second pass
  assign e_fwd = {target[31], target} - {angle[31], angle};
  assign e_rev = {angle[31], angle} - {target[31], target};

  // saturating error sum
  always_comb begin
    s49 = {int_old[47], int_old} + {{16{err[32]}}, err};
    if (s49[48] != s49[47]) begin
      sum_next = s49[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
    end else begin
      sum_next = $signed(s49[47:0]);
    end
    sum_mag_next = sum_next[47] ? (48'd0 - sum_next) : sum_next;
  end

  // signed p and i terms in 2^-24 v
  assign pterm = err_neg ? (60'd0 - {12'd0, pm}) : {12'd0, pm};
  assign iterm = sum_neg ? (60'd0 - {2'd0, div_q[57:0]}) : {2'd0, div_q[57:0]};
  assign vmag  = vreg[59] ? (60'd0 - vreg) : vreg;
  assign vx    = vmag[59:jpmd_pkg::DAC_SHIFT];

  // dac offset: reciprocal of three unless the clamp applies
  assign off = big ? jpmd_pkg::DAC_SPAN
                   : prod[jpmd_pkg::RECIP3_SHIFT+14:jpmd_pkg::RECIP3_SHIFT];

  // direction pair of the current joint, zero voltage counts as reverse
  always_comb begin
    sh       = {jr, 1'b0};
    pair     = (vpos ^ (jr == jpmd_pkg::INVERTED_JOINT)) ? 2'b10 : 2'b01;
    dir_next = (direction_bits & ~(16'd3 << sh)) | ({14'd0, pair} << sh);
  end

  // multiplier operands by step
  always_comb begin
    case (state)
      S_SUM: begin
        mul_a = err_mag;
        mul_b = kp;
      end
      S_MUL_ILO: begin
        mul_a = sum_mag[31:0];
        mul_b = ki;
      end
      S_MUL_IHI: begin
        mul_a = {16'd0, sum_mag[47:32]};
        mul_b = ki;
      end
      S_MUL_DAC: begin
        mul_a = {16'd0, x16};
        mul_b = jpmd_pkg::RECIP3;
      end
      default: begin
        mul_a = diff_mag;
        mul_b = scale_sel;
      end
    endcase
  end

  // configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < jpmd_pkg::SCALE_REGS; i++) begin
        scale[i] <= jpmd_pkg::scale_reset(SW'(i));
      end
      kp <= jpmd_pkg::KP_RESET;
      ki <= jpmd_pkg::KI_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        jpmd_pkg::REG_KP: kp <= cfg_data;
        jpmd_pkg::REG_KI: ki <= cfg_data;
        default: begin
          if (cfg_index < jpmd_pkg::CFG_IDX_W'(jpmd_pkg::SCALE_REGS)) begin
            scale[cfg_index[SW-1:0]] <= cfg_data;
          end
        end
      endcase
    end
  end

  // per-joint error sums
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < JOINTS; i++) begin
        integral[i] <= '0;
      end
    end else if (state == S_SUM) begin
      integral[jr[JW-1:0]] <= sum_next;
    end
  end

  // sequencer with its working registers and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      direction_bits <= jpmd_pkg::DIR_RESET;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take && joint_ok) begin
            jr        <= in_data.joint;
            diff_neg  <= diff_up[32];
            diff_mag  <= diff_up[32] ? diff_dn[31:0] : diff_up[31:0];
            target    <= in_data.target_angle;
            scale_sel <= scale[in_data.joint[SW-1:0]];
            int_old   <= integral[in_data.joint[JW-1:0]];
            state     <= S_MUL_ANG;
          end
        end
        S_MUL_ANG: state <= S_ANGLE;
        S_ANGLE: begin
          angle <= angle_next;
          state <= S_ERR;
        end
        S_ERR: begin
          err     <= $signed(e_fwd);
          err_neg <= e_fwd[32];
          err_mag <= e_fwd[32] ? e_rev[31:0] : e_fwd[31:0];
          state   <= S_SUM;
        end
        S_SUM: begin
          sum_neg <= sum_next[47];
          sum_mag <= sum_mag_next;
          state   <= S_MUL_ILO;
        end
        S_MUL_ILO: begin
          pm    <= prod[63:16];
          state <= S_MUL_IHI;
        end
        S_MUL_IHI: begin
          acc   <= {16'd0, prod};
          state <= S_IACC;
        end
        S_IACC: begin
          acc   <= acc + {prod[47:0], 32'd0};
          state <= S_DIV_GO;
        end
        S_DIV_GO: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state <= S_VOLT;
          end
        end
        S_VOLT: begin
          vreg  <= $signed(pterm + iterm);
          state <= S_MAG;
        end
        S_MAG: begin
          vpos  <= !vreg[59] && (vreg != '0);
          big   <= (vx >= {31'd0, jpmd_pkg::DAC_CLAMP_X});
          x16   <= vx[15:0];
          state <= S_MUL_DAC;
        end
        S_MUL_DAC: state <= S_DAC;
        S_DAC: begin
          dac   <= jpmd_pkg::DAC_ZERO + {1'b0, off};
          state <= S_DONE;
        end
        S_DONE: begin
          if (slot_free) begin
            direction_bits          <= dir_next;
            out_data.dac_code       <= dac;
            out_data.direction_word <= dir_next;
            out_data.measured_angle <= angle;
            out_valid               <= 1'b1;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/jpmd_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpmd_mul
// shared 32x32 unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module jpmd_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);

  logic [63:0] prod_next;

  assign prod_next = {32'd0, a} * {32'd0, b};

  always_ff @(posedge clk) begin
    prod <= prod_next;
  end

endmodule

// ----- hw/rtl/jpmd_div100.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpmd_div100
// digit-serial divide by the sample-rate constant, four quotient bits a cycle
// ----------------------------------------------------------------------------
module jpmd_div100 (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [jpmd_pkg::DIV_W-1:0]   dividend,
  output logic [jpmd_pkg::DIV_W-1:0]   quotient,
  output logic                         done
);

  localparam int W     = jpmd_pkg::DIV_W;
  localparam int DG    = jpmd_pkg::DIV_DIGIT;
  localparam int RW    = jpmd_pkg::DIV_REM_W;
  localparam int STEPS = W / DG;
  localparam int CNT_W = $clog2(STEPS);
  localparam logic [RW:0] DIVISOR = (RW + 1)'(jpmd_pkg::DIV_BY);

  logic [W-1:0]     dvd;
  logic [RW-1:0]    rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [RW-1:0]    rem_next;
  logic [DG-1:0]    qbits;
  logic [RW:0]      trial;

  // restoring steps, one per quotient bit
  always_comb begin
    rem_next = rem;
    qbits    = '0;
    trial    = '0;
    for (int k = 0; k < DG; k++) begin
      trial = {rem_next, dvd[W-1-k]};
      if (trial >= DIVISOR) begin
        trial        = trial - DIVISOR;
        qbits[DG-1-k] = 1'b1;
      end
      rem_next = trial[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvd      <= dividend;
        quotient <= '0;
        rem      <= '0;
        cnt      <= CNT_W'(STEPS - 1);
        busy     <= 1'b1;
      end else if (busy) begin
        dvd      <= {dvd[W-DG-1:0], {DG{1'b0}}};
        quotient <= {quotient[W-DG-1:0], qbits};
        rem      <= rem_next;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

// ----- verif/tb_joint_pi_motor_drive.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_joint_pi_motor_drive
// self-checking bench for the per-joint pi drive
// ----------------------------------------------------------------------------
// words go in with random gaps while the result side stalls at random. Every
// accepted word is run through a local fixed-point copy of the drive, which
// predicts the dac code, the direction word and the measured angle. Each
// result word is compared field by field with the oldest prediction. The
// gain and scale registers are reloaded between phases, only once the block
// has gone quiet.
// ----------------------------------------------------------------------------
module tb_joint_pi_motor_drive;
  import jpmd_pkg::*;

  localparam int     CLK_PERIOD         = 10;
  localparam int     RESET_CYCLES       = 8;
  // idle margin after the last predicted result word has come back
  localparam int     SETTLE_CYCLES      = 64;
  localparam longint LIMIT_NS           = 80_000_000;
  localparam int     RANDOM_PER_SETTING = 70;
  localparam int     MAX_REPORTS        = 60;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam longint             SUM_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint             SUM_MIN   = -SUM_MAX - 1;
  localparam logic signed [31:0] ANGLE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ANGLE_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] TEN_DEG   = 32'sd655360;
  // one dac code in units of 2^-24 v: 24 v over 16384 codes
  localparam longint             DAC_STEP  = 24576;
  // scale that lands a single count exactly on half a q16.16 step
  localparam logic [31:0]        HALF_STEP = 32'h0080_0000;

  typedef logic [REG_KI:REG_SCALE_ONE][31:0] reg_file_t;

  localparam reg_file_t REGS_AT_RESET = {
    KI_RESET, KP_RESET, 32'd229873744, 32'd109951163,
    32'd89960042, 32'd59357268, 32'd98956047
  };

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [31:0]           cfg_data;

  // local copy of the drive state
  reg_file_t   drive_regs;
  longint      joint_error_sum [JOINTS_DEF];
  logic [15:0] direction_bits_q;

  // result words predicted but not yet seen, oldest first
  out_word_t   drive_results_due [$];

  int mismatches = 0;
  // burst flags switch off the random gaps on either side
  bit in_burst   = 1'b0;
  bit out_burst  = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  joint_pi_motor_drive dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // fixed-point drive model
  // --------------------------------------------------------------------------

  function automatic logic [63:0] magnitude(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  // gain times magnitude over 2^16, truncated
  function automatic logic [63:0] gain_product(input logic [31:0] gain,
                                               input logic [63:0] mag);
    logic [95:0] prod;
    prod = {64'b0, gain} * {32'b0, mag};
    return prod[79:16];
  endfunction

  // count offset from preset times scale, rounded half away from zero, saturated
  function automatic logic signed [31:0] angle_from_count(input logic [31:0] count,
                                                          input logic [31:0] scale);
    longint      diff;
    logic [65:0] prod;
    logic [65:0] q;
    logic [31:0] low;
    diff = longint'({32'b0, count}) - longint'({32'b0, COUNT_PRESET_DEF});
    prod = {2'b0, magnitude(diff)} * {34'b0, scale};
    q    = (prod + (66'd1 << 23)) >> 24;
    low  = q[31:0];
    if (diff < 0) return (q > 66'h8000_0000) ? ANGLE_MIN : -low;
    return (q > 66'h7FFF_FFFF) ? ANGLE_MAX : low;
  endfunction

  // advances the local state by one word; returns 0 for a dropped word
  function automatic bit predict_drive(input in_word_t w, output out_word_t r);
    logic [2:0]         j;
    logic signed [31:0] angle;
    longint             err;
    longint             sum;
    longint             v;
    logic [63:0]        pm;
    logic [63:0]        im;
    logic [63:0]        off;
    logic [1:0]         pair;
    int                 sh;
    r = '0;
    if (w.joint >= JOINTS_DEF) return 1'b0;
    j     = w.joint;
    angle = angle_from_count(w.encoder_count, drive_regs[REG_SCALE_ONE + j]);
    err   = longint'(w.target_angle) - longint'(angle);

    // error sum saturates at 48 bits
    sum = joint_error_sum[j] + err;
    if (sum > SUM_MAX) sum = SUM_MAX;
    if (sum < SUM_MIN) sum = SUM_MIN;
    joint_error_sum[j] = sum;

    // i term carries the 0.01 s sample period as a divide by 100
    pm = gain_product(drive_regs[REG_KP], magnitude(err));
    im = gain_product(drive_regs[REG_KI], magnitude(sum)) / 64'd100;
    v  = ((err < 0) ? -longint'(pm) : longint'(pm)) +
         ((sum < 0) ? -longint'(im) : longint'(im));

    off = magnitude(v) / DAC_STEP;
    if (off > DAC_SPAN) off = DAC_SPAN;

    // zero drive counts as reverse; the inverted joint swaps its pair
    if (j == INVERTED_JOINT) pair = (v > 0) ? 2'b01 : 2'b10;
    else pair = (v > 0) ? 2'b10 : 2'b01;
    sh = 2 * j;
    direction_bits_q = (direction_bits_q & ~(16'h0003 << sh)) | ({14'b0, pair} << sh);

    r.dac_code       = DAC_ZERO + off[15:0];
    r.direction_word = direction_bits_q;
    r.measured_angle = angle;
    return 1'b1;
  endfunction

  function automatic in_word_t drive_word(input logic [2:0] joint,
                                          input logic [31:0] count,
                                          input logic signed [31:0] target);
    in_word_t w;
    w.joint         = joint;
    w.encoder_count = count;
    w.target_angle  = target;
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // channel tasks
  // --------------------------------------------------------------------------

  // one input word; valid stays high on return so back-to-back words need no gap
  task automatic send_drive_word(input in_word_t w);
    int        gap;
    out_word_t r;
    gap = in_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (predict_drive(w, r)) drive_results_due.push_back(r);
  endtask

  // sender holds off until every predicted word has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (drive_results_due.size() != 0) @(posedge clk);
  endtask

  // quiet block: nothing due and any dropped word has drained through
  task automatic settle_drive();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // valid stays high on return; the caller drops it after the last write
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx <= REG_KI) drive_regs[idx] = value;
  endtask

  task automatic load_registers(input reg_file_t vals);
    logic [CFG_IDX_W-1:0] idx;
    settle_drive();
    idx = REG_SCALE_ONE;
    repeat (REG_KI - REG_SCALE_ONE + 1) begin
      write_register(idx, vals[idx]);
      idx++;
    end
    cfg_valid <= 1'b0;
  endtask

  // mixed random words: mostly small tracking errors near the preset,
  // some wholly random words and some for joints that do not exist
  task automatic send_random_words(input int count);
    int                 sent;
    int                 pick;
    int                 span;
    int                 tspan;
    in_word_t           w;
    logic signed [31:0] angle;
    longint             t;
    sent = 0;
    while (sent < count) begin
      if (sent % 40 == 0) begin
        in_burst  = ($urandom_range(0, 3) == 0);
        out_burst = ($urandom_range(0, 3) == 0);
      end
      pick            = $urandom_range(0, 99);
      w.joint         = $urandom_range(0, JOINTS_DEF - 1);
      w.encoder_count = $urandom();
      w.target_angle  = $urandom();
      if (pick < 12) begin
        w.joint = $urandom_range(JOINTS_DEF, 7);
      end else if (pick >= 30) begin
        span            = 1 << $urandom_range(0, 20);
        w.encoder_count = COUNT_PRESET_DEF + (int'($urandom_range(0, 2 * span)) - span);
        angle = angle_from_count(w.encoder_count, drive_regs[REG_SCALE_ONE + w.joint]);
        tspan = 1 << $urandom_range(0, 22);
        t     = longint'(angle) + (int'($urandom_range(0, 2 * tspan)) - tspan);
        if (t > ANGLE_MAX) t = ANGLE_MAX;
        if (t < ANGLE_MIN) t = ANGLE_MIN;
        w.target_angle = t[31:0];
      end
      if ($urandom_range(0, 59) == 0) wait_for_results();
      send_drive_word(w);
      if (pick >= 12) sent++;
    end
    in_burst  = 1'b0;
    out_burst = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // fresh joint on its preset with zero target: no drive, reverse pair
  task automatic test_zero_drive();
    send_drive_word(drive_word(3'd0, COUNT_PRESET_DEF, 32'sd0));
  endtask

  // forward then reverse on each joint, the inverted joint included
  task automatic test_direction_pairs();
    for (int k = 0; k < JOINTS_DEF; k++) begin
      send_drive_word(drive_word(k[2:0], COUNT_PRESET_DEF, TEN_DEG));
      send_drive_word(drive_word(k[2:0], COUNT_PRESET_DEF, -TEN_DEG));
    end
  endtask

  // joint indexes past the last joint are taken and dropped
  task automatic test_missing_joints();
    for (int k = JOINTS_DEF; k < 8; k++)
      send_drive_word(drive_word(k[2:0], $urandom(), $urandom()));
    send_drive_word(drive_word(3'd2, COUNT_PRESET_DEF, TEN_DEG));
    settle_drive();
  endtask

  // counter and target at their limits; angle saturates both ways
  task automatic test_field_extremes();
    send_drive_word(drive_word(3'd0, 32'h0000_0000, ANGLE_MAX));
    send_drive_word(drive_word(3'd1, 32'hFFFF_FFFF, ANGLE_MIN));
    send_drive_word(drive_word(3'd4, 32'h0000_0000, 32'sd0));
    send_drive_word(drive_word(3'd2, COUNT_PRESET_DEF, ANGLE_MAX));
    send_drive_word(drive_word(3'd3, 32'hFFFF_FFFF, ANGLE_MIN));
  endtask

  // a write to the empty index must leave every register alone
  task automatic test_unused_register();
    settle_drive();
    write_register(REG_UNUSED, $urandom());
    cfg_valid <= 1'b0;
    send_drive_word(drive_word(3'd1, COUNT_PRESET_DEF + 32'd4000, TEN_DEG));
    send_drive_word(drive_word(3'd4, COUNT_PRESET_DEF - 32'd4000, -TEN_DEG));
  endtask

  // half-step angles must round away from zero on both sides
  task automatic test_rounding_ties();
    reg_file_t gains;
    gains = REGS_AT_RESET;
    for (int k = 0; k < JOINTS_DEF; k++) gains[REG_SCALE_ONE + k] = HALF_STEP;
    load_registers(gains);
    send_drive_word(drive_word(3'd0, COUNT_PRESET_DEF + 32'd1, 32'sd0));
    send_drive_word(drive_word(3'd1, COUNT_PRESET_DEF - 32'd1, 32'sd0));
    send_drive_word(drive_word(3'd2, COUNT_PRESET_DEF + 32'd3, 32'sd0));
    send_drive_word(drive_word(3'd3, COUNT_PRESET_DEF - 32'd3, 32'sd0));
  endtask

  // defaults, all ones, all zeros, then random register sets
  task automatic test_random_settings();
    reg_file_t gains;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: gains = REGS_AT_RESET;
        1: gains = '1;
        2: gains = '0;
        default: begin
          for (int k = 0; k < JOINTS_DEF; k++)
            gains[REG_SCALE_ONE + k] = ($urandom_range(0, 4) == 0) ?
                                       $urandom() : $urandom_range(1 << 20, 1 << 28);
          gains[REG_KP] = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 1 << 27);
          gains[REG_KI] = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 1 << 22);
        end
      endcase
      load_registers(gains);
      send_random_words(RANDOM_PER_SETTING);
    end
  endtask

  // full-scale error on one joint until its error sum pins, then back off
  task automatic test_integral_saturation();
    reg_file_t gains;
    gains                = REGS_AT_RESET;
    gains[REG_SCALE_ONE] = '1;
    load_registers(gains);
    in_burst  = 1'b1;
    out_burst = 1'b1;
    while (joint_error_sum[0] != SUM_MAX)
      send_drive_word(drive_word(3'd0, 32'h0000_0000, ANGLE_MAX));
    repeat (20) send_drive_word(drive_word(3'd0, 32'h0000_0000, ANGLE_MAX));
    repeat (10) send_drive_word(drive_word(3'd0, 32'hFFFF_FFFF, ANGLE_MIN));
    in_burst  = 1'b0;
    out_burst = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // result side
  // --------------------------------------------------------------------------

  // random stall before each result word, none while in a burst
  initial begin : result_stall
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      hold = out_burst ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t %s expected %0h got %0h", $time, field, want, got);
    end
  endtask

  // compare every accepted result word with the oldest prediction
  always @(posedge clk) begin : check_results
    out_word_t due;
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (drive_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t unexpected result word expected none got %h", $time, out_data);
      end else begin
        due = drive_results_due.pop_front();
        report_field("dac_code", due.dac_code, out_data.dac_code);
        report_field("direction_word", due.direction_word, out_data.direction_word);
        report_field("measured_angle", due.measured_angle, out_data.measured_angle);
      end
    end
  end

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_SCALE_ONE;
    cfg_data  <= '0;

    drive_regs = REGS_AT_RESET;
    foreach (joint_error_sum[k]) joint_error_sum[k] = 0;
    direction_bits_q = DIR_RESET;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_zero_drive();
    test_direction_pairs();
    test_missing_joints();
    test_field_extremes();
    test_unused_register();
    test_rounding_ties();
    test_random_settings();
    test_integral_saturation();

    settle_drive();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
